### design/assert_macros.svh
// Assertion macros shared by the design files.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/idwe_pkg.sv
// Package of the index delta width encoder: command and field codes, widths and types.
// No dependencies; used by the encoder top level.
package idwe_pkg;

  localparam int MAX_INDICES_DEF = 1024;
  localparam int FIELD_W = 32;
  localparam int BITS_W = 6;
  localparam int KIND_W = 3;
  localparam int W_START = 3;
  localparam int W_MAX = 32;
  localparam int RUN_BITS = 24;
  localparam int FULL_BITS = 32;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_PULL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_COUNT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RUN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELTA = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SCAN = 3'b100
  } ctl_state_t;

  typedef enum logic [5:0] {
    PH_LOADING = 6'b000001,
    PH_COUNT   = 6'b000010,
    PH_FIRST   = 6'b000100,
    PH_RUNCNT  = 6'b001000,
    PH_DELTA   = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

endpackage

### design/idwe_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; instanced by the encoder top level for the index store.
module idwe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/index_delta_width_encoder.sv
// Index delta width encoder: loads up to MAX_INDICES indices, then hands out count,
// first index, run counts and deltas one field per pull. A count or empty pull answers
// straight from the registers, a first index or delta pull through the index RAM read
// in S_READ, and a run count pull through S_SCAN, one RAM read per scanned delta.
// Synchronous active-low reset empties the set; no clearing pass.
// Depends on idwe_pkg, idwe_ram and assert_macros.svh.
`include "assert_macros.svh"

module index_delta_width_encoder #(
  parameter int MAX_INDICES = idwe_pkg::MAX_INDICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [idwe_pkg::FIELD_W-1:0]  in_index_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [idwe_pkg::FIELD_W-1:0]  out_field_value,
  output logic [idwe_pkg::BITS_W-1:0]   out_field_bits,
  output logic [idwe_pkg::KIND_W-1:0]   out_field_kind,
  output logic                          out_last_field,
  output logic                          out_overflow
);

  localparam int AW = $clog2(MAX_INDICES);
  localparam int CW = $clog2(MAX_INDICES + 1);
  localparam int DW = idwe_pkg::FIELD_W;
  localparam int BW = idwe_pkg::BITS_W;

  idwe_pkg::ctl_state_t state_r, state_nxt;
  idwe_pkg::phase_t     phase_r, phase_nxt;

  logic [CW-1:0] stored_count_r, stored_count_nxt;
  logic [CW-1:0] emit_cursor_r, emit_cursor_nxt;
  logic [CW-1:0] run_end_r, run_end_nxt;
  logic [BW-1:0] current_width_r, current_width_nxt;
  logic [DW-1:0] previous_index_r, previous_index_nxt;
  logic          overflow_seen_r, overflow_seen_nxt;
  logic [CW-1:0] scan_j_r, scan_j_nxt;
  logic [DW-1:0] scan_prev_r, scan_prev_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_value_r, out_value_nxt;
  logic [BW-1:0] out_bits_r, out_bits_nxt;
  logic [idwe_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          out_load;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [DW-1:0] ram_rd;

  logic          out_free, in_acc, busy, pull_acc, scan_ok;
  logic [CW-1:0] load_count, cursor_inc, scan_j_inc, run_len;
  logic [DW-1:0] diff, scan_diff, scan_mag;
  logic [BW-1:0] width_m1;
  logic          scan_fits, width_at_max;

  idwe_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_INDICES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (in_index_value),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign busy = state_r != idwe_pkg::S_IDLE;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy || ((in_command == idwe_pkg::CMD_PULL) && !out_free);
  assign in_acc = in_valid && !in_stall;
  assign pull_acc = in_acc && (in_command == idwe_pkg::CMD_PULL);
  assign scan_ok = (scan_j_r >= emit_cursor_r) && (scan_j_r <= stored_count_r);

  assign load_count = (phase_r == idwe_pkg::PH_LOADING) ? stored_count_r : '0;
  assign cursor_inc = emit_cursor_r + CW'(1);
  assign scan_j_inc = scan_j_r + CW'(1);
  assign run_len = scan_j_r - emit_cursor_r;
  assign diff = (ram_rd - previous_index_r) & ~({DW{1'b1}} << current_width_r);
  assign scan_diff = ram_rd - scan_prev_r;
  assign scan_mag = scan_diff[DW-1] ? ~scan_diff : scan_diff;
  assign width_m1 = current_width_r - BW'(1);
  assign scan_fits = (scan_mag >> width_m1) == '0;
  assign width_at_max = current_width_r >= BW'(idwe_pkg::W_MAX);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    stored_count_nxt = stored_count_r;
    emit_cursor_nxt = emit_cursor_r;
    run_end_nxt = run_end_r;
    current_width_nxt = current_width_r;
    previous_index_nxt = previous_index_r;
    overflow_seen_nxt = overflow_seen_r;
    scan_j_nxt = scan_j_r;
    scan_prev_nxt = scan_prev_r;
    ram_we = 1'b0;
    ram_wa = load_count[AW-1:0];
    ram_re = 1'b0;
    ram_ra = emit_cursor_r[AW-1:0];
    out_load = 1'b0;
    out_value_nxt = '0;
    out_bits_nxt = '0;
    out_kind_nxt = idwe_pkg::KIND_NONE;
    out_last_nxt = 1'b0;

    unique case (state_r)
      idwe_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_command)
            idwe_pkg::CMD_LOAD: begin
              phase_nxt = idwe_pkg::PH_LOADING;
              if (phase_r != idwe_pkg::PH_LOADING) begin
                overflow_seen_nxt = 1'b0;
              end
              if (load_count < CW'(MAX_INDICES)) begin
                ram_we = 1'b1;
                stored_count_nxt = load_count + CW'(1);
              end else begin
                stored_count_nxt = load_count;
                overflow_seen_nxt = 1'b1;
              end
            end
            idwe_pkg::CMD_CLOSE: begin
              if (phase_r == idwe_pkg::PH_LOADING) begin
                phase_nxt = idwe_pkg::PH_COUNT;
              end
            end
            idwe_pkg::CMD_PULL: begin
              unique case (phase_r)
                idwe_pkg::PH_COUNT: begin
                  out_load = 1'b1;
                  out_value_nxt = DW'(stored_count_r);
                  out_bits_nxt = BW'(idwe_pkg::FULL_BITS);
                  out_kind_nxt = idwe_pkg::KIND_COUNT;
                  if (stored_count_r == '0) begin
                    out_last_nxt = 1'b1;
                    phase_nxt = idwe_pkg::PH_DONE;
                  end else begin
                    phase_nxt = idwe_pkg::PH_FIRST;
                  end
                end
                idwe_pkg::PH_FIRST: begin
                  ram_re = 1'b1;
                  ram_ra = '0;
                  state_nxt = idwe_pkg::S_READ;
                end
                idwe_pkg::PH_RUNCNT: begin
                  ram_re = emit_cursor_r < stored_count_r;
                  scan_j_nxt = emit_cursor_r;
                  scan_prev_nxt = previous_index_r;
                  state_nxt = idwe_pkg::S_SCAN;
                end
                idwe_pkg::PH_DELTA: begin
                  if (emit_cursor_r < stored_count_r) begin
                    ram_re = 1'b1;
                    state_nxt = idwe_pkg::S_READ;
                  end else begin
                    out_load = 1'b1;
                    phase_nxt = idwe_pkg::PH_DONE;
                  end
                end
                default: begin
                  out_load = 1'b1;
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end
      idwe_pkg::S_READ: begin
        out_load = 1'b1;
        state_nxt = idwe_pkg::S_IDLE;
        previous_index_nxt = ram_rd;
        if (phase_r == idwe_pkg::PH_FIRST) begin
          emit_cursor_nxt = CW'(1);
          current_width_nxt = BW'(idwe_pkg::W_START);
          out_value_nxt = ram_rd;
          out_bits_nxt = BW'(idwe_pkg::FULL_BITS);
          out_kind_nxt = idwe_pkg::KIND_FIRST;
          out_last_nxt = stored_count_r <= CW'(1);
          phase_nxt = (stored_count_r <= CW'(1)) ? idwe_pkg::PH_DONE : idwe_pkg::PH_RUNCNT;
        end else begin
          emit_cursor_nxt = cursor_inc;
          out_value_nxt = diff;
          out_bits_nxt = current_width_r;
          out_kind_nxt = idwe_pkg::KIND_DELTA;
          if (cursor_inc >= stored_count_r) begin
            out_last_nxt = 1'b1;
            phase_nxt = idwe_pkg::PH_DONE;
          end else if (cursor_inc >= run_end_r) begin
            if (width_at_max) begin
              phase_nxt = idwe_pkg::PH_DONE;
            end else begin
              current_width_nxt = current_width_r + BW'(1);
              phase_nxt = idwe_pkg::PH_RUNCNT;
            end
          end
        end
      end
      idwe_pkg::S_SCAN: begin
        if ((scan_j_r < stored_count_r) && scan_fits) begin
          scan_prev_nxt = ram_rd;
          scan_j_nxt = scan_j_inc;
          ram_re = scan_j_inc < stored_count_r;
          ram_ra = scan_j_inc[AW-1:0];
        end else begin
          out_load = 1'b1;
          state_nxt = idwe_pkg::S_IDLE;
          run_end_nxt = scan_j_r;
          out_value_nxt = DW'(run_len);
          out_bits_nxt = BW'(idwe_pkg::RUN_BITS);
          out_kind_nxt = idwe_pkg::KIND_RUN;
          if (run_len != '0) begin
            phase_nxt = idwe_pkg::PH_DELTA;
          end else if (width_at_max) begin
            phase_nxt = idwe_pkg::PH_DONE;
          end else begin
            current_width_nxt = current_width_r + BW'(1);
          end
        end
      end
      default: begin
        state_nxt = idwe_pkg::S_IDLE;
      end
    endcase

    out_ovf_nxt = overflow_seen_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= idwe_pkg::S_IDLE;
      phase_r <= idwe_pkg::PH_LOADING;
      stored_count_r <= '0;
      emit_cursor_r <= '0;
      run_end_r <= '0;
      current_width_r <= BW'(idwe_pkg::W_START);
      previous_index_r <= '0;
      overflow_seen_r <= 1'b0;
      scan_j_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      stored_count_r <= stored_count_nxt;
      emit_cursor_r <= emit_cursor_nxt;
      run_end_r <= run_end_nxt;
      current_width_r <= current_width_nxt;
      previous_index_r <= previous_index_nxt;
      overflow_seen_r <= overflow_seen_nxt;
      scan_j_r <= scan_j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_prev_r <= scan_prev_nxt;
    if (out_load) begin
      out_value_r <= out_value_nxt;
      out_bits_r <= out_bits_nxt;
      out_kind_r <= out_kind_nxt;
      out_last_r <= out_last_nxt;
      out_ovf_r <= out_ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_field_value = out_value_r;
  assign out_field_bits = out_bits_r;
  assign out_field_kind = out_kind_r;
  assign out_last_field = out_last_r;
  assign out_overflow = out_ovf_r;

  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, stored_count_r <= CW'(MAX_INDICES))
  `ASSERT_IMPL(a_scan_window, clk, rst_n, state_r == idwe_pkg::S_SCAN, scan_ok)
  `ASSERT_IMPL(a_result_cause, clk, rst_n, $rose(out_valid_r), $past(pull_acc) || $past(busy))

endmodule
